// ===== sv/pat_pkg.sv =====
// Shared definitions for the polygon affine transform core: field widths,
// command and register codes, the microcode table and arithmetic helpers.
// No dependencies.
package pat_pkg;

    localparam int POINTS_DEFAULT = 7;
    localparam int COORD_W = 24;
    localparam int PIXEL_W = 16;
    localparam int COEF_W = 16;
    localparam int CMD_W = 3;
    localparam int SEL_W = 3;
    localparam int CFG_IDX_W = 8;
    localparam int DIFF_W = COORD_W + 1;
    localparam int MULC_W = COEF_W + 1;
    localparam int PROD_W = DIFF_W + MULC_W;
    localparam int SUM_W = COORD_W + 5;
    localparam int FRAC_SH = 14;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_LOAD_POINT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_PIVOT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROT_POS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ROT_NEG = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GROW = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SHRINK = 3'd6;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_COS_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_STEP = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROW_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK_GAIN = 8'd3;
    localparam logic [COEF_W-1:0] COS_STEP_RST = 16'd15850;
    localparam logic [COEF_W-1:0] SIN_STEP_RST = 16'd4149;
    localparam logic [COEF_W-1:0] GROW_GAIN_RST = 16'd17695;
    localparam logic [COEF_W-1:0] SHRINK_GAIN_RST = 16'd15073;

    // Microcode field codes.
    localparam logic [1:0] COEF_C = 2'd0;
    localparam logic [1:0] COEF_S = 2'd1;
    localparam logic [1:0] COEF_G = 2'd2;
    localparam logic OP_DX = 1'b0;
    localparam logic OP_DY = 1'b1;
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD = 2'd2;
    localparam logic [1:0] ACC_SUB = 2'd3;
    localparam logic [2:0] SEQ_IDLE = 3'd0;
    localparam logic [2:0] SEQ_NEXT = 3'd1;
    localparam logic [2:0] SEQ_DISPATCH = 3'd2;
    localparam logic [2:0] SEQ_JUMP = 3'd3;
    localparam logic [2:0] SEQ_EMIT = 3'd4;
    localparam logic [2:0] SEQ_FIN = 3'd5;

    // Microcode addresses.
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UA_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] UA_READ = 4'd1;
    localparam logic [UPC_W-1:0] UA_DIFF = 4'd2;
    localparam logic [UPC_W-1:0] UA_ROT = 4'd3;
    localparam logic [UPC_W-1:0] UA_ROT_B = 4'd4;
    localparam logic [UPC_W-1:0] UA_ROT_C = 4'd5;
    localparam logic [UPC_W-1:0] UA_ROT_D = 4'd6;
    localparam logic [UPC_W-1:0] UA_ROT_E = 4'd7;
    localparam logic [UPC_W-1:0] UA_ROT_F = 4'd8;
    localparam logic [UPC_W-1:0] UA_SCALE = 4'd9;
    localparam logic [UPC_W-1:0] UA_SCALE_B = 4'd10;
    localparam logic [UPC_W-1:0] UA_SCALE_C = 4'd11;
    localparam logic [UPC_W-1:0] UA_SCALE_D = 4'd12;
    localparam logic [UPC_W-1:0] UA_MOVE = 4'd13;
    localparam logic [UPC_W-1:0] UA_EMIT = 4'd14;
    localparam logic [UPC_W-1:0] UA_FIN = 4'd15;

    typedef struct packed {
        logic             rd_en;
        logic             diff_en;
        logic             mul_en;
        logic [1:0]       coef_sel;
        logic             op_sel;
        logic [1:0]       acc_op;
        logic             fin_x;
        logic             fin_y;
        logic             mv_en;
        logic [2:0]       seq;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    // Per point: read, offset from pivot, then the arithmetic of the command.
    // Products land in the step after they are issued, so the middle steps both issue
    // a multiply and fold in the previous product.
    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_word_t w;
        w = '0;
        w.seq = SEQ_NEXT;
        case (addr)
            UA_IDLE: begin
                w.seq = SEQ_IDLE;
            end
            UA_READ: begin
                w.rd_en = 1'b1;
            end
            UA_DIFF: begin
                w.diff_en = 1'b1;
                w.seq = SEQ_DISPATCH;
            end
            UA_ROT: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_C; w.op_sel = OP_DX;
            end
            UA_ROT_B: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_S; w.op_sel = OP_DY;
                w.acc_op = ACC_LOAD;
            end
            UA_ROT_C: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_S; w.op_sel = OP_DX;
                w.acc_op = ACC_SUB;
            end
            UA_ROT_D: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_C; w.op_sel = OP_DY;
                w.acc_op = ACC_LOAD; w.fin_x = 1'b1;
            end
            UA_ROT_E: begin
                w.acc_op = ACC_ADD;
            end
            UA_ROT_F: begin
                w.fin_y = 1'b1; w.seq = SEQ_JUMP; w.target = UA_EMIT;
            end
            UA_SCALE: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_G; w.op_sel = OP_DX;
            end
            UA_SCALE_B: begin
                w.mul_en = 1'b1; w.coef_sel = COEF_G; w.op_sel = OP_DY;
                w.acc_op = ACC_LOAD;
            end
            UA_SCALE_C: begin
                w.acc_op = ACC_LOAD; w.fin_x = 1'b1;
            end
            UA_SCALE_D: begin
                w.fin_y = 1'b1; w.seq = SEQ_JUMP; w.target = UA_EMIT;
            end
            UA_MOVE: begin
                w.mv_en = 1'b1; w.seq = SEQ_JUMP; w.target = UA_EMIT;
            end
            UA_EMIT: begin
                w.seq = SEQ_EMIT; w.target = UA_READ;
            end
            UA_FIN: begin
                w.seq = SEQ_FIN; w.target = UA_IDLE;
            end
            default: begin
                w.seq = SEQ_FIN; w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

    // Clamp a widened coordinate to the signed Q15.8 range.
    function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] lim;
        lim = {{(SUM_W-COORD_W+1){v[COORD_W-1]}}, v[COORD_W-2:0]};
        if (lim == v) begin
            return v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // Round Q15.8 to the nearest pixel, halves away from zero, saturated.
    function automatic logic [PIXEL_W-1:0] to_pixel(input logic [COORD_W-1:0] v);
        logic [COORD_W:0]   mag;
        logic [COORD_W-8:0] r;
        mag = v[COORD_W-1] ? (~{1'b1, v} + 1'b1) : {1'b0, v};
        mag = mag + (COORD_W+1)'(128);
        r = mag[COORD_W:8];
        if (v[COORD_W-1]) begin
            return PIXEL_W'(~r + 1'b1);
        end else if (|r[COORD_W-8:PIXEL_W-1]) begin
            return {1'b0, {(PIXEL_W-1){1'b1}}};
        end else begin
            return r[PIXEL_W-1:0];
        end
    endfunction

endpackage

// ===== sv/polygon_affine_transform_core.sv =====
// Top level of the polygon affine transform core: point table, pivot,
// configuration registers, microcoded sequencer and shared multiply unit.
// Depends on pat_pkg.

// The core holds a table of POINTS polygon points and a pivot, all signed
// Q15.8. A load point or load pivot item is taken and gives no
// result; command 7 is taken and ignored. A rotate, grow, shrink or move item
// walks every point in table order and sends one result item per point, with
// the saturated new coordinates, rounded pixel coordinates and last_point on
// the final one. The walk is run by a 16-word microcode table over one
// 17 x 25 bit multiplier and a single table read port, so the four products
// of a rotate are issued one after another for each point. A point waits in
// the emit step only while the result register is still full. Configuration
// writes are taken at any time (cfg_ready is always high) but must only come
// while the core is idle; writes to an index beyond the four registers are
// dropped.
module polygon_affine_transform_core #(
    parameter int POINTS = pat_pkg::POINTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Command input.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pat_pkg::CMD_W-1:0]           s_cmd,
    input  logic [pat_pkg::SEL_W-1:0]           s_point_sel,
    input  logic signed [pat_pkg::COORD_W-1:0]  s_load_x,
    input  logic signed [pat_pkg::COORD_W-1:0]  s_load_y,
    input  logic signed [pat_pkg::COORD_W-1:0]  s_move_dx,
    input  logic signed [pat_pkg::COORD_W-1:0]  s_move_dy,
    // Result output.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pat_pkg::SEL_W-1:0]           m_point_index,
    output logic signed [pat_pkg::COORD_W-1:0]  m_point_x,
    output logic signed [pat_pkg::COORD_W-1:0]  m_point_y,
    output logic signed [pat_pkg::PIXEL_W-1:0]  m_pixel_x,
    output logic signed [pat_pkg::PIXEL_W-1:0]  m_pixel_y,
    output logic                                m_last_point,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pat_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pat_pkg::COEF_W-1:0]          cfg_data
);
    import pat_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

    // Configuration registers.
    logic [COEF_W-1:0] cos_reg, sin_reg, grow_reg, shrink_reg;

    // Point table and pivot.
    logic [COORD_W-1:0] x_mem [POINTS];
    logic [COORD_W-1:0] y_mem [POINTS];
    logic [COORD_W-1:0] pivot_x_reg, pivot_y_reg;
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg;

    // Sequencer state.
    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [COORD_W-1:0] mx_reg, my_reg;
    ctrl_word_t cw;

    // Datapath.
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [MULC_W-1:0] coef;
    logic signed [DIFF_W-1:0] mul_op;
    logic signed [PROD_W-1:0] prod_reg, acc_reg, acc_rnd;
    logic [SUM_W-1:0] fin_x_sum, fin_y_sum, mv_x_sum, mv_y_sum, pv_x_sum, pv_y_sum;
    logic [COORD_W-1:0] nx_reg, ny_reg;

    // Result register.
    logic m_valid_reg;
    logic [SEL_W-1:0] out_idx_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [PIXEL_W-1:0] out_px_reg, out_py_reg;
    logic out_last_reg;

    logic in_fire, is_transform, emit_ok, emit_fire, load_fire;

    assign cw = ucode_rom(upc_reg);
    assign s_ready = (upc_reg == UA_IDLE);
    assign in_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign is_transform = s_cmd inside {[CMD_ROT_POS:CMD_SHRINK]};
    assign load_fire = in_fire && (s_cmd == CMD_LOAD_POINT) && (int'(s_point_sel) < POINTS);

    // A result may be loaded when the register is empty or being drained.
    assign emit_ok = !m_valid_reg || m_ready;
    assign emit_fire = (cw.seq == SEQ_EMIT) && emit_ok;

    always_comb begin
        upc_next = upc_reg;
        idx_next = idx_reg;
        case (cw.seq)
            SEQ_IDLE: begin
                if (in_fire && is_transform) begin
                    upc_next = UA_READ;
                    idx_next = '0;
                end
            end
            SEQ_NEXT: begin
                upc_next = upc_reg + 1'b1;
            end
            SEQ_DISPATCH: begin
                case (cmd_reg)
                    CMD_ROT_POS, CMD_ROT_NEG: upc_next = UA_ROT;
                    CMD_MOVE: upc_next = UA_MOVE;
                    default: upc_next = UA_SCALE;
                endcase
            end
            SEQ_JUMP: begin
                upc_next = cw.target;
            end
            SEQ_EMIT: begin
                if (emit_ok) begin
                    if (idx_reg == LAST_IDX) begin
                        upc_next = UA_FIN;
                    end else begin
                        upc_next = cw.target;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                upc_next = cw.target;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_IDLE;
            idx_reg <= '0;
        end else begin
            upc_reg <= upc_next;
            idx_reg <= idx_next;
        end
    end

    // Configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg <= COS_STEP_RST;
            sin_reg <= SIN_STEP_RST;
            grow_reg <= GROW_GAIN_RST;
            shrink_reg <= SHRINK_GAIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COS_STEP: cos_reg <= cfg_data;
                REG_SIN_STEP: sin_reg <= cfg_data;
                REG_GROW_GAIN: grow_reg <= cfg_data;
                REG_SHRINK_GAIN: shrink_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Command latch for the walk.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg <= s_cmd;
            mx_reg <= s_move_dx;
            my_reg <= s_move_dy;
        end
    end

    // Point table: one write port shared by loads and write-back, one read port.
    always_ff @(posedge aclk) begin
        if (load_fire) begin
            x_mem[IDX_W'(s_point_sel)] <= s_load_x;
            y_mem[IDX_W'(s_point_sel)] <= s_load_y;
        end else if (emit_fire) begin
            x_mem[idx_reg] <= nx_reg;
            y_mem[idx_reg] <= ny_reg;
        end
        if (cw.rd_en) begin
            rd_x_reg <= x_mem[idx_reg];
            rd_y_reg <= y_mem[idx_reg];
        end
    end

    // Pivot: loaded directly, moved at the end of a move walk.
    assign pv_x_sum = {{5{pivot_x_reg[COORD_W-1]}}, pivot_x_reg} + {{5{mx_reg[COORD_W-1]}}, mx_reg};
    assign pv_y_sum = {{5{pivot_y_reg[COORD_W-1]}}, pivot_y_reg} + {{5{my_reg[COORD_W-1]}}, my_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
        end else if (in_fire && s_cmd == CMD_LOAD_PIVOT) begin
            pivot_x_reg <= s_load_x;
            pivot_y_reg <= s_load_y;
        end else if (cw.seq == SEQ_FIN && cmd_reg == CMD_MOVE) begin
            pivot_x_reg <= sat_coord(pv_x_sum);
            pivot_y_reg <= sat_coord(pv_y_sum);
        end
    end

    // Coefficient and operand selection for the shared multiplier. A negative
    // rotation uses the negated sine, which needs the extra bit.
    always_comb begin
        case (cw.coef_sel)
            COEF_C: coef = {cos_reg[COEF_W-1], cos_reg};
            COEF_S: begin
                if (cmd_reg == CMD_ROT_NEG) begin
                    coef = -$signed({sin_reg[COEF_W-1], sin_reg});
                end else begin
                    coef = {sin_reg[COEF_W-1], sin_reg};
                end
            end
            default: coef = (cmd_reg == CMD_GROW) ? {1'b0, grow_reg} : {1'b0, shrink_reg};
        endcase
        mul_op = (cw.op_sel == OP_DY) ? dy_reg : dx_reg;
    end

    // Round to nearest at the Q14 point, then add back the pivot.
    assign acc_rnd = acc_reg + PROD_W'(1 << (FRAC_SH - 1));
    assign fin_x_sum = {{5{pivot_x_reg[COORD_W-1]}}, pivot_x_reg}
                     + {acc_rnd[PROD_W-1], acc_rnd[PROD_W-1:FRAC_SH]};
    assign fin_y_sum = {{5{pivot_y_reg[COORD_W-1]}}, pivot_y_reg}
                     + {acc_rnd[PROD_W-1], acc_rnd[PROD_W-1:FRAC_SH]};
    assign mv_x_sum = {{5{rd_x_reg[COORD_W-1]}}, rd_x_reg} + {{5{mx_reg[COORD_W-1]}}, mx_reg};
    assign mv_y_sum = {{5{rd_y_reg[COORD_W-1]}}, rd_y_reg} + {{5{my_reg[COORD_W-1]}}, my_reg};

    always_ff @(posedge aclk) begin
        if (cw.diff_en) begin
            dx_reg <= $signed({rd_x_reg[COORD_W-1], rd_x_reg})
                    - $signed({pivot_x_reg[COORD_W-1], pivot_x_reg});
            dy_reg <= $signed({rd_y_reg[COORD_W-1], rd_y_reg})
                    - $signed({pivot_y_reg[COORD_W-1], pivot_y_reg});
        end
        if (cw.mul_en) begin
            prod_reg <= coef * mul_op;
        end
        case (cw.acc_op)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD: acc_reg <= acc_reg + prod_reg;
            ACC_SUB: acc_reg <= acc_reg - prod_reg;
            default: ;
        endcase
        if (cw.fin_x) begin
            nx_reg <= sat_coord(fin_x_sum);
        end
        if (cw.fin_y) begin
            ny_reg <= sat_coord(fin_y_sum);
        end
        if (cw.mv_en) begin
            nx_reg <= sat_coord(mv_x_sum);
            ny_reg <= sat_coord(mv_y_sum);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            out_idx_reg <= SEL_W'(idx_reg);
            out_x_reg <= nx_reg;
            out_y_reg <= ny_reg;
            out_px_reg <= to_pixel(nx_reg);
            out_py_reg <= to_pixel(ny_reg);
            out_last_reg <= (idx_reg == LAST_IDX);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_point_index = out_idx_reg;
    assign m_point_x = out_x_reg;
    assign m_point_y = out_y_reg;
    assign m_pixel_x = out_px_reg;
    assign m_pixel_y = out_py_reg;
    assign m_last_point = out_last_reg;

endmodule
